// File: hw/rtl/mahd_pkg.sv
package mahd_pkg;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadSync    = 3'd1,
    StResVersion = 3'd2,
    StResLayer   = 3'd3,
    StBadBitrate = 3'd4,
    StResRate    = 3'd5
  } status_e;

  // Decoded header handed from the front to the back.
  typedef struct packed {
    status_e     status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding_bit;
    logic [1:0]  channel_code;
    logic [1:0]  rate_idx;
  } hdr_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding_bit;
    logic [1:0]  channel_code;
    logic [11:0] frame_bytes;
  } res_t;

  localparam logic [10:0] Layer1Factor  = 11'd120;
  localparam logic [10:0] Layer23Factor = 11'd1440;

  localparam int          RecipShift = 20;
  localparam logic [8:0]  Div44k     = 9'd441;
  localparam logic [8:0]  Div48k     = 9'd480;
  localparam logic [8:0]  Div32k     = 9'd320;
  localparam logic [11:0] Recip44k   = 12'((1 << RecipShift) / 441);
  localparam logic [11:0] Recip48k   = 12'((1 << RecipShift) / 480);
  localparam logic [11:0] Recip32k   = 12'((1 << RecipShift) / 320);

  // Index: [low sampling frequency][layer][bitrate index]
  localparam logic [8:0] BrTab [2][3][16] = '{
    '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    }
  };

  localparam logic [15:0] HzTab [3][4] = '{
    '{16'd44100, 16'd48000, 16'd32000, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd11025, 16'd12000, 16'd8000,  16'd0}
  };

  // Base rate divided by 100; lower versions fold into the dividend shift.
  function automatic logic [8:0] rate_div(input logic [1:0] idx);
    logic [8:0] d;
    unique case (idx)
      2'd0:    d = Div44k;
      2'd1:    d = Div48k;
      default: d = Div32k;
    endcase
    return d;
  endfunction

  function automatic logic [11:0] rate_recip(input logic [1:0] idx);
    logic [11:0] r;
    unique case (idx)
      2'd0:    r = Recip44k;
      2'd1:    r = Recip48k;
      default: r = Recip32k;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/mahd_fifo.sv
module mahd_fifo import mahd_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

// File: hw/rtl/mahd_front.sv
module mahd_front import mahd_pkg::*; (
  input  logic [31:0] header_word_i,
  output hdr_t        hdr_o
);

  logic [7:0] b0, b1, b2, b3;
  logic [1:0] vbits, lbits, sidx, ver, lay, mode;
  logic [3:0] bidx;
  logic       lsf;

  assign b0    = header_word_i[31:24];
  assign b1    = header_word_i[23:16];
  assign b2    = header_word_i[15:8];
  assign b3    = header_word_i[7:0];
  assign vbits = b1[4:3];
  assign lbits = b1[2:1];
  assign bidx  = b2[7:4];
  assign sidx  = b2[3:2];
  assign mode  = b3[7:6];
  assign ver   = (vbits == 2'd3) ? 2'd0 : (vbits == 2'd2) ? 2'd1 : 2'd2;
  assign lay   = 2'd3 - lbits;
  assign lsf   = (ver != 2'd0);

  // First failing check sets the status; a rejected word carries zeros.
  always_comb begin
    hdr_o = '0;
    priority if (b0 != 8'hFF || b1[7:5] != 3'b111) begin
      hdr_o.status = StBadSync;
    end else if (vbits == 2'd1) begin
      hdr_o.status = StResVersion;
    end else if (lbits == 2'd0) begin
      hdr_o.status = StResLayer;
    end else if (bidx == 4'd0 || bidx == 4'd15) begin
      hdr_o.status = StBadBitrate;
    end else if (sidx == 2'd3) begin
      hdr_o.status = StResRate;
    end else begin
      hdr_o.status         = StOk;
      hdr_o.version_code   = ver;
      hdr_o.layer_code     = lay;
      hdr_o.bitrate_kbps   = BrTab[lsf][lay][bidx];
      hdr_o.sample_rate_hz = HzTab[ver][sidx];
      hdr_o.padding_bit    = b2[1];
      hdr_o.channel_code   = mode + 2'd1;
      hdr_o.rate_idx       = sidx;
    end
  end

endmodule

// File: hw/rtl/mahd_back.sv
module mahd_back import mahd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_empty_i,
  input  hdr_t in_hdr_i,
  output logic in_pop_o,
  input  logic out_full_i,
  output logic out_push_o,
  output res_t out_res_o
);

  // Slots are floor(K*br*2^ver/d) + padding, d = base rate / 100.
  // Quotient comes from a truncated reciprocal, low by at most one.
  typedef struct packed {
    hdr_t        hdr;
    logic [19:0] dividend;
    logic [8:0]  divisor;
  } div_t;

  div_t        s1_q, s1_d, s2_q, s3_q;
  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  logic [11:0] recip1_q;
  logic [11:0] q0_2_q, q0_3_q;
  logic [20:0] qd3_q;
  logic [19:0] prod1;
  logic [21:0] shifted1;
  logic [31:0] recip_prod;
  logic [19:0] diff3;
  logic [11:0] quot3, sum3, len3;

  assign rdy3     = !v3_q || !out_full_i;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;
  assign in_pop_o = rdy1 && !in_empty_i;

  assign prod1    = 20'((in_hdr_i.layer_code == 2'd0) ? Layer1Factor : Layer23Factor)
                  * 20'(in_hdr_i.bitrate_kbps);
  assign shifted1 = {2'b00, prod1} << in_hdr_i.version_code;

  always_comb begin
    s1_d.hdr      = in_hdr_i;
    // Largest dividend is 921600, inside 20 bits.
    s1_d.dividend = shifted1[19:0];
    s1_d.divisor  = rate_div(in_hdr_i.rate_idx);
  end

  assign recip_prod = 32'(s1_q.dividend) * 32'(recip1_q);

  // Fix up the estimate and form the length.
  assign diff3 = s3_q.dividend - qd3_q[19:0];
  assign quot3 = q0_3_q + 12'(diff3 >= 20'(s3_q.divisor));
  assign sum3  = quot3 + 12'(s3_q.hdr.padding_bit);
  assign len3  = (s3_q.hdr.layer_code == 2'd0) ? {sum3[9:0], 2'b00} : sum3;

  always_comb begin
    out_res_o.status         = s3_q.hdr.status;
    out_res_o.version_code   = s3_q.hdr.version_code;
    out_res_o.layer_code     = s3_q.hdr.layer_code;
    out_res_o.bitrate_kbps   = s3_q.hdr.bitrate_kbps;
    out_res_o.sample_rate_hz = s3_q.hdr.sample_rate_hz;
    out_res_o.padding_bit    = s3_q.hdr.padding_bit;
    out_res_o.channel_code   = s3_q.hdr.channel_code;
    out_res_o.frame_bytes    = (s3_q.hdr.status == StOk) ? len3 : '0;
  end

  assign out_push_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= !in_empty_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_q     <= s1_d;
      recip1_q <= rate_recip(in_hdr_i.rate_idx);
    end
    if (rdy2) begin
      s2_q   <= s1_q;
      q0_2_q <= recip_prod[31:20];
    end
    if (rdy3) begin
      s3_q   <= s2_q;
      q0_3_q <= q0_2_q;
      qd3_q  <= 21'(q0_2_q) * 21'(s2_q.divisor);
    end
  end

  a_remainder_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_q.hdr.status == StOk |-> diff3 < {s3_q.divisor, 1'b0})
    else $error("quotient estimate off by more than one");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && s3_q.hdr.status == StOk |-> len3 != '0)
    else $error("valid header produced zero frame length");

endmodule

// File: hw/rtl/mpeg_audio_header_decode_unit.sv
// Decodes one 32-bit MPEG audio frame header word (first byte in bits 31:24)
// into status, version, layer, bitrate, sample rate, padding, channel mode and
// frame length in bytes. Rejected words report the first failing check and
// zero in every other field. A word can be pushed every cycle while full is
// low. The frame length comes from a three-stage reciprocal multiply with a
// one-step correction, which takes a new word each cycle unless the full
// result queue stalls it. Full rises when the QueueDepth-entry queue in front
// of that pipeline fills, which happens only while the ResultDepth-entry
// result queue is held full by a stalled pop.
module mpeg_audio_header_decode_unit import mahd_pkg::*; #(
  parameter int QueueDepth  = 2,
  parameter int ResultDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] header_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [1:0]  version_code_o,
  output logic [1:0]  layer_code_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic        padding_bit_o,
  output logic [1:0]  channel_code_o,
  output logic [11:0] frame_bytes_o
);

  hdr_t hdr_in, hdr_mid;
  res_t res_back, res_out;
  logic mid_empty, mid_pop;
  logic res_full, res_push;
  logic [$bits(hdr_t)-1:0] mid_rdata;
  logic [$bits(res_t)-1:0] res_rdata;

  mahd_front u_front (
    .header_word_i(header_word_i),
    .hdr_o        (hdr_in)
  );

  mahd_fifo #(
    .Width($bits(hdr_t)),
    .Depth(QueueDepth)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(hdr_in),
    .full_o (full),
    .pop_i  (mid_pop),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty)
  );

  assign hdr_mid = hdr_t'(mid_rdata);

  mahd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_empty_i(mid_empty),
    .in_hdr_i  (hdr_mid),
    .in_pop_o  (mid_pop),
    .out_full_i(res_full),
    .out_push_o(res_push),
    .out_res_o (res_back)
  );

  mahd_fifo #(
    .Width($bits(res_t)),
    .Depth(ResultDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_back),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign res_out          = res_t'(res_rdata);
  assign status_o         = res_out.status;
  assign version_code_o   = res_out.version_code;
  assign layer_code_o     = res_out.layer_code;
  assign bitrate_kbps_o   = res_out.bitrate_kbps;
  assign sample_rate_hz_o = res_out.sample_rate_hz;
  assign padding_bit_o    = res_out.padding_bit;
  assign channel_code_o   = res_out.channel_code;
  assign frame_bytes_o    = res_out.frame_bytes;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o != StOk |->
      frame_bytes_o == '0 && bitrate_kbps_o == '0 && sample_rate_hz_o == '0)
    else $error("rejected word carries nonzero fields");

endmodule

// File: test/mpeg_audio_header_decode_unit_tb.sv
module mpeg_audio_header_decode_unit_tb;
  import mahd_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int RandomWords = 1500;
  localparam int ChunkWords  = 150;

  // Rows: MPEG-1 layer I/II/III, low sampling frequency layer I, layer II/III.
  localparam int unsigned KbpsTable [5][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };

  localparam int unsigned HzTable [3][3] = '{
    '{44100, 48000, 32000},
    '{22050, 24000, 16000},
    '{11025, 12000, 8000}
  };

  typedef enum int {
    PhaseSteady,
    PhaseSenderIdle,
    PhaseReceiverStall,
    PhaseBothIdle
  } phase_e;

  typedef struct {
    logic [31:0] word;
    phase_e      phase;
    bit          drain;
  } header_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] header_word = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status_o;
  logic [1:0]  version_code_o;
  logic [1:0]  layer_code_o;
  logic [8:0]  bitrate_kbps_o;
  logic [15:0] sample_rate_hz_o;
  logic        padding_bit_o;
  logic [1:0]  channel_code_o;
  logic [11:0] frame_bytes_o;

  header_item_t pending_headers[$];
  res_t         decoded_expected[$];
  phase_e       cur_phase = PhaseSteady;
  logic         word_taken = 1'b0;
  int           mismatches = 0;
  int           words_in = 0;
  int           results_out = 0;
  int           status_seen [6];
  int           idle_cycles = 0;

  mpeg_audio_header_decode_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .header_word_i   (header_word),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .version_code_o  (version_code_o),
    .layer_code_o    (layer_code_o),
    .bitrate_kbps_o  (bitrate_kbps_o),
    .sample_rate_hz_o(sample_rate_hz_o),
    .padding_bit_o   (padding_bit_o),
    .channel_code_o  (channel_code_o),
    .frame_bytes_o   (frame_bytes_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic res_t decode_header(input logic [31:0] w);
    res_t        r;
    logic [1:0]  vbits;
    logic [1:0]  lbits;
    logic [3:0]  bidx;
    logic [1:0]  sidx;
    int unsigned ver;
    int unsigned lay;
    int unsigned row;
    int unsigned br;
    int unsigned sr;
    int unsigned len;
    r = '0;
    vbits = w[20:19];
    lbits = w[18:17];
    bidx = w[15:12];
    sidx = w[11:10];
    // First failing check wins; every other field stays zero.
    if (w[31:21] != 11'h7FF) begin
      r.status = StBadSync;
    end else if (vbits == 2'b01) begin
      r.status = StResVersion;
    end else if (lbits == 2'b00) begin
      r.status = StResLayer;
    end else if (bidx == 4'd0 || bidx == 4'd15) begin
      r.status = StBadBitrate;
    end else if (sidx == 2'd3) begin
      r.status = StResRate;
    end else begin
      ver = (vbits == 2'b11) ? 0 : (vbits == 2'b10) ? 1 : 2;
      lay = 3 - lbits;
      row = (ver == 0) ? lay : (lay == 0) ? 3 : 4;
      br = KbpsTable[row][bidx];
      sr = HzTable[ver][sidx];
      if (lay == 0) len = ((12 * br * 1000 / sr) + w[9]) * 4;
      else len = (144 * br * 1000 / sr) + w[9];
      r.status = StOk;
      r.version_code = 2'(ver);
      r.layer_code = 2'(lay);
      r.bitrate_kbps = 9'(br);
      r.sample_rate_hz = 16'(sr);
      r.padding_bit = w[9];
      r.channel_code = w[7:6] + 2'd1;
      r.frame_bytes = 12'(len);
    end
    return r;
  endfunction

  function automatic logic [31:0] make_header(input logic [1:0] v, input logic [1:0] l,
                                              input logic [3:0] b, input logic [1:0] s,
                                              input logic pad, input logic [1:0] m);
    return {8'hFF, 3'b111, v, l, 1'($urandom), b, s, pad, 1'($urandom), m,
            6'($urandom)};
  endfunction

  // Mostly well-formed headers with random content; the rest broken or noise.
  function automatic logic [31:0] random_header();
    logic [1:0]  v;
    logic [1:0]  l;
    logic [3:0]  b;
    logic [1:0]  s;
    logic [31:0] w;
    int unsigned pick;
    v = 2'($urandom);
    l = 2'($urandom);
    b = 4'($urandom);
    s = 2'($urandom);
    if (v == 2'b01 && $urandom_range(0, 9) != 0) v = 2'b11;
    if (l == 2'b00 && $urandom_range(0, 9) != 0) l = 2'($urandom_range(1, 3));
    if ((b == 4'd0 || b == 4'd15) && $urandom_range(0, 9) != 0)
      b = 4'($urandom_range(1, 14));
    if (s == 2'd3 && $urandom_range(0, 9) != 0) s = 2'($urandom_range(0, 2));
    w = make_header(v, l, b, s, 1'($urandom), 2'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 8) w[21 + $urandom_range(0, 10)] = 1'b0;
    else if (pick < 20) w = $urandom;
    return w;
  endfunction

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic add_header(input logic [31:0] w, input phase_e ph, input bit drain);
    header_item_t it;
    it.word = w;
    it.phase = ph;
    it.drain = drain;
    pending_headers.push_back(it);
  endtask

  // Driver: advance to the next word once the current one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && word_taken) pending_headers.delete(0);
      if (!push || word_taken) begin
        if (pending_headers.size() == 0) begin
          push <= 1'b0;
        end else if (pending_headers[0].drain && decoded_expected.size() != 0) begin
          push <= 1'b0;
        end else begin
          cur_phase = pending_headers[0].phase;
          if ((cur_phase == PhaseSenderIdle && chance(47)) ||
              (cur_phase == PhaseBothIdle && chance(21))) begin
            push <= 1'b0;
          end else begin
            push <= 1'b1;
            header_word <= pending_headers[0].word;
          end
        end
      end
      if ((cur_phase == PhaseReceiverStall && chance(47)) ||
          (cur_phase == PhaseBothIdle && chance(21))) pop <= 1'b0;
      else pop <= 1'b1;
    end
  end

  // Monitor: record accepted words, check each popped result against the oldest.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      word_taken <= push && !full;
      if (push && !full) begin
        decoded_expected.push_back(decode_header(header_word));
        words_in++;
      end
      if (pop && !empty) begin
        results_out++;
        if (decoded_expected.size() == 0) begin
          $error("result with status %0d popped while none was expected", status_o);
          mismatches++;
        end else begin
          exp_r = decoded_expected.pop_front();
          if (exp_r.status <= StResRate) status_seen[exp_r.status]++;
          check_field("status", exp_r.status, status_o);
          check_field("version_code", exp_r.version_code, version_code_o);
          check_field("layer_code", exp_r.layer_code, layer_code_o);
          check_field("bitrate_kbps", exp_r.bitrate_kbps, bitrate_kbps_o);
          check_field("sample_rate_hz", exp_r.sample_rate_hz, sample_rate_hz_o);
          check_field("padding_bit", exp_r.padding_bit, padding_bit_o);
          check_field("channel_code", exp_r.channel_code, channel_code_o);
          check_field("frame_bytes", exp_r.frame_bytes, frame_bytes_o);
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no word moved for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int   chunk;
    logic p;
    // Extremes of every table, each rejection, each channel mode.
    add_header(make_header(2'b11, 2'b11, 4'd14, 2'd2, 1'b1, 2'd0), PhaseSteady, 1'b0);
    add_header(make_header(2'b11, 2'b11, 4'd1, 2'd0, 1'b0, 2'd1), PhaseSteady, 1'b0);
    add_header(make_header(2'b11, 2'b10, 4'd14, 2'd1, 1'b1, 2'd2), PhaseSteady, 1'b0);
    add_header(make_header(2'b11, 2'b01, 4'd14, 2'd0, 1'b1, 2'd3), PhaseSteady, 1'b0);
    add_header(make_header(2'b11, 2'b01, 4'd1, 2'd2, 1'b0, 2'd0), PhaseSteady, 1'b0);
    add_header(make_header(2'b10, 2'b11, 4'd14, 2'd2, 1'b1, 2'd1), PhaseSteady, 1'b0);
    add_header(make_header(2'b10, 2'b10, 4'd14, 2'd2, 1'b0, 2'd2), PhaseSteady, 1'b0);
    add_header(make_header(2'b10, 2'b01, 4'd1, 2'd1, 1'b1, 2'd3), PhaseSteady, 1'b0);
    add_header(make_header(2'b00, 2'b01, 4'd14, 2'd2, 1'b1, 2'd0), PhaseSteady, 1'b0);
    add_header(make_header(2'b00, 2'b11, 4'd1, 2'd1, 1'b0, 2'd1), PhaseSteady, 1'b0);
    add_header(make_header(2'b00, 2'b10, 4'd7, 2'd0, 1'b1, 2'd2), PhaseSteady, 1'b0);
    add_header(make_header(2'b01, 2'b01, 4'd5, 2'd0, 1'b0, 2'd0), PhaseSteady, 1'b0);
    add_header(make_header(2'b11, 2'b00, 4'd5, 2'd0, 1'b0, 2'd0), PhaseSteady, 1'b0);
    add_header(make_header(2'b11, 2'b01, 4'd0, 2'd0, 1'b0, 2'd0), PhaseSteady, 1'b0);
    add_header(make_header(2'b10, 2'b11, 4'd15, 2'd0, 1'b0, 2'd0), PhaseSteady, 1'b0);
    add_header(make_header(2'b00, 2'b01, 4'd9, 2'd3, 1'b1, 2'd3), PhaseSteady, 1'b0);
    // Reserved version with a reserved layer still reports the version.
    add_header(make_header(2'b01, 2'b00, 4'd0, 2'd3, 1'b1, 2'd3), PhaseSteady, 1'b0);
    add_header(32'h0000_0000, PhaseSteady, 1'b0);
    add_header(32'hFFFF_FFFF, PhaseSteady, 1'b0);
    add_header(32'hFFDF_FFFF, PhaseSteady, 1'b0);
    add_header(32'hFEFF_FFFF, PhaseSteady, 1'b0);
    add_header(32'h7FFF_FFFF, PhaseSteady, 1'b0);
    for (int i = 0; i < RandomWords; i++) begin
      chunk = i / ChunkWords;
      // Hold the first word of each chunk until the block has drained.
      p = (i % ChunkWords) == 0;
      add_header(random_header(), phase_e'(chunk % 4), p);
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_headers.size() != 0 || push) @(posedge clk_i);
    while (decoded_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d header words and %0d results under steady, idle and stall phases",
             words_in, results_out);
    $display("status counts ok/sync/version/layer/bitrate/rate: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
